/* rtl/core/rrts_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin tick scheduler package
// Shared types, task-table entry layout, result layout and state codes.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int NumTasksDef = 16;
    localparam int TimeSliceRst = 2;

    typedef enum logic [2:0] {
        PH_UNUSED   = 3'd0,
        PH_INACTIVE = 3'd1,
        PH_READY    = 3'd2,
        PH_RUNNING  = 3'd3,
        PH_WAITING  = 3'd4,
        PH_DONE     = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_DONE    = 2'd1,
        END_PREEMPT = 2'd2
    } t_end;

    typedef enum logic [0:0] {
        OP_DEFINE = 1'b0,
        OP_TICK   = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_RUN_RD,
        S_RUN_WR,
        S_DISP_RD,
        S_DISP_TK,
        S_DISP_WR,
        S_FINISH
    } t_state;

    // one task-table entry
    typedef struct packed {
        t_phase      phase;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] run;
        logic        responded;
    } t_task_ent;

    // input item payload, task_id in the low bits
    typedef struct packed {
        logic [15:0] burst_time;
        logic [15:0] arrival_time;
        logic [3:0]  task_id;
    } t_cmd;

    // result item, current_time in the low bits
    typedef struct packed {
        logic        all_done;
        logic [31:0] total_waiting;
        logic [4:0]  ready_count;
        logic [15:0] response_time;
        logic        started;
        t_end        end_kind;
        logic [3:0]  ended_task;
        logic [3:0]  run_slot;
        logic        running_valid;
        logic [15:0] current_time;
    } t_result;

endpackage

/* rtl/core/rrts_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* rtl/core/rrts_core.sv */
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Defines task-table entries; per tick walks the task table once, updates the
// running task, dispatches from the ready queue. Builds a result per item.
// ----------------------------------------------------------------------------
module rrts_core #(
    parameter int SLOT_CNT = rrts_pkg::NumTasksDef
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [7:0]                       i_time_slice,
    input  logic                             i_in_valid,
    input  rrts_pkg::t_op                    i_op,
    input  rrts_pkg::t_cmd                   i_cmd,
    output logic                             o_in_ready,
    // task table port
    output logic                             o_tk_we,
    output logic [$clog2(SLOT_CNT)-1:0]      o_tk_waddr,
    output rrts_pkg::t_task_ent              o_tk_wdata,
    output logic [$clog2(SLOT_CNT)-1:0]      o_tk_raddr,
    input  rrts_pkg::t_task_ent              i_tk_rdata,
    // ready queue port
    output logic                             o_ff_we,
    output logic [$clog2(SLOT_CNT)-1:0]      o_ff_waddr,
    output logic [$clog2(SLOT_CNT)-1:0]      o_ff_wdata,
    output logic [$clog2(SLOT_CNT)-1:0]      o_ff_raddr,
    input  logic [$clog2(SLOT_CNT)-1:0]      i_ff_rdata,
    // result
    input  logic                             i_out_free,
    output logic                             o_res_valid,
    output rrts_pkg::t_result                o_res
);

    localparam int ID_W = $clog2(SLOT_CNT);
    localparam int CNT_W = ID_W + 1;
    localparam logic [CNT_W-1:0] NumC = CNT_W'(SLOT_CNT);
    localparam logic [ID_W-1:0] LastId = ID_W'(SLOT_CNT - 1);

    rrts_pkg::t_state r_state, n_state;

    logic [CNT_W-1:0] r_idx;
    logic             r_pv;
    logic [ID_W-1:0]  r_pidx;
    logic [ID_W-1:0]  r_head;
    logic [CNT_W-1:0] r_count;
    logic             r_running;
    logic [ID_W-1:0]  r_run_idx;
    logic [8:0]       r_slice;
    logic [15:0]      r_tick;
    logic [CNT_W-1:0] r_defined;
    logic [CNT_W-1:0] r_arrived;
    logic [31:0]      r_wait;
    logic             r_used [SLOT_CNT];
    logic [ID_W-1:0]  r_pop_id;
    rrts_pkg::t_op    r_op;
    logic [ID_W-1:0]  r_ended;
    rrts_pkg::t_end   r_kind;
    logic             r_started;
    logic [15:0]      r_resp;

    logic             acc;
    logic             def_ok;
    logic [ID_W-1:0]  def_id;
    rrts_pkg::t_phase sc_phase;
    logic             sc_push;
    logic             sc_arrive;
    logic             sc_wait;
    logic             sc_issue;
    logic [CNT_W-1:0] tail_sum;
    logic [ID_W-1:0]  tail;
    logic [15:0]      run_nxt;
    logic [8:0]       slice_nxt;
    logic [8:0]       limit;
    logic             boundary;
    logic             run_done;

    assign acc    = i_in_valid && (r_state == rrts_pkg::S_IDLE);
    assign def_id = ID_W'(i_cmd.task_id);
    assign def_ok = (int'(i_cmd.task_id) < SLOT_CNT) && !r_used[def_id];

    assign tail_sum = CNT_W'(r_head) + r_count;
    assign tail     = (tail_sum >= NumC) ? ID_W'(tail_sum - NumC) : ID_W'(tail_sum);
    assign sc_issue = (r_state == rrts_pkg::S_SCAN) && (r_idx < NumC);

    // per-slot decision during the scan
    always_comb begin
        sc_phase  = r_used[r_pidx] ? i_tk_rdata.phase : rrts_pkg::PH_UNUSED;
        sc_push   = 1'b0;
        sc_arrive = 1'b0;
        sc_wait   = 1'b0;
        if (r_state == rrts_pkg::S_SCAN && r_pv) begin
            priority if (sc_phase == rrts_pkg::PH_WAITING) begin
                sc_push = 1'b1;
                sc_wait = 1'b1;
            end else if (sc_phase == rrts_pkg::PH_INACTIVE && i_tk_rdata.arrival <= r_tick) begin
                sc_push   = 1'b1;
                sc_arrive = 1'b1;
            end else if (sc_phase == rrts_pkg::PH_READY) begin
                sc_wait = 1'b1;
            end else begin
                sc_push = 1'b0;
            end
        end
    end

    // running task update
    always_comb begin
        run_nxt   = (i_tk_rdata.run != 16'hFFFF) ? i_tk_rdata.run + 16'd1 : i_tk_rdata.run;
        slice_nxt = r_slice + 9'd1;
        limit     = {(i_time_slice == 8'd0), i_time_slice};
        boundary  = slice_nxt >= limit;
        run_done  = run_nxt >= i_tk_rdata.burst;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rrts_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_op == rrts_pkg::OP_TICK) ? rrts_pkg::S_SCAN
                                                          : rrts_pkg::S_FINISH;
                end
            end
            rrts_pkg::S_SCAN: begin
                if (r_pv && r_pidx == LastId) begin
                    n_state = rrts_pkg::S_RUN_RD;
                end
            end
            rrts_pkg::S_RUN_RD: begin
                n_state = r_running ? rrts_pkg::S_RUN_WR : rrts_pkg::S_DISP_RD;
            end
            rrts_pkg::S_RUN_WR: begin
                n_state = rrts_pkg::S_DISP_RD;
            end
            rrts_pkg::S_DISP_RD: begin
                n_state = (!r_running && r_count != '0) ? rrts_pkg::S_DISP_TK
                                                        : rrts_pkg::S_FINISH;
            end
            rrts_pkg::S_DISP_TK: begin
                n_state = rrts_pkg::S_DISP_WR;
            end
            rrts_pkg::S_DISP_WR: begin
                n_state = rrts_pkg::S_FINISH;
            end
            rrts_pkg::S_FINISH: begin
                if (i_out_free) begin
                    n_state = rrts_pkg::S_IDLE;
                end
            end
            default: n_state = rrts_pkg::S_IDLE;
        endcase
    end

    // memory ports and handshake
    always_comb begin
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_tk_we     = 1'b0;
        o_tk_waddr  = r_pidx;
        o_tk_wdata  = i_tk_rdata;
        o_tk_raddr  = r_idx[ID_W-1:0];
        o_ff_we     = 1'b0;
        o_ff_waddr  = tail;
        o_ff_wdata  = r_pidx;
        o_ff_raddr  = r_head;
        unique case (r_state)
            rrts_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_tk_we    = acc && (i_op == rrts_pkg::OP_DEFINE) && def_ok;
                o_tk_waddr = def_id;
                o_tk_wdata = '{phase: rrts_pkg::PH_INACTIVE, arrival: i_cmd.arrival_time,
                               burst: i_cmd.burst_time, run: 16'd0, responded: 1'b0};
            end
            rrts_pkg::S_SCAN: begin
                o_tk_we          = sc_push;
                o_tk_wdata.phase = rrts_pkg::PH_READY;
                o_ff_we          = sc_push;
            end
            rrts_pkg::S_RUN_RD: begin
                o_tk_raddr = r_run_idx;
            end
            rrts_pkg::S_RUN_WR: begin
                o_tk_we        = 1'b1;
                o_tk_waddr     = r_run_idx;
                o_tk_wdata.run = run_nxt;
                if (run_done) begin
                    o_tk_wdata.phase = rrts_pkg::PH_DONE;
                end else if (r_count != '0 && boundary) begin
                    o_tk_wdata.phase = rrts_pkg::PH_WAITING;
                end
            end
            rrts_pkg::S_DISP_RD: begin
                o_ff_raddr = r_head;
            end
            rrts_pkg::S_DISP_TK: begin
                o_tk_raddr = i_ff_rdata;
            end
            rrts_pkg::S_DISP_WR: begin
                o_tk_we              = 1'b1;
                o_tk_waddr           = r_pop_id;
                o_tk_wdata.phase     = rrts_pkg::PH_RUNNING;
                o_tk_wdata.responded = 1'b1;
            end
            rrts_pkg::S_FINISH: begin
                o_res_valid = i_out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    always_comb begin
        o_res.current_time  = r_tick;
        o_res.running_valid = r_running;
        o_res.run_slot      = r_running ? 4'(r_run_idx) : 4'd0;
        o_res.ended_task    = 4'(r_ended);
        o_res.end_kind      = r_kind;
        o_res.started       = r_started;
        o_res.response_time = r_resp;
        o_res.ready_count   = 5'(r_count);
        o_res.total_waiting = r_wait;
        o_res.all_done      = (r_arrived == r_defined) && (r_count == '0) && !r_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrts_pkg::S_IDLE;
            r_idx     <= '0;
            r_pv      <= 1'b0;
            r_head    <= '0;
            r_count   <= '0;
            r_running <= 1'b0;
            r_run_idx <= '0;
            r_slice   <= '0;
            r_tick    <= '0;
            r_defined <= '0;
            r_arrived <= '0;
            r_wait    <= '0;
            r_op      <= rrts_pkg::OP_DEFINE;
            r_ended   <= '0;
            r_kind    <= rrts_pkg::END_NONE;
            r_started <= 1'b0;
            r_resp    <= '0;
            for (int i = 0; i < SLOT_CNT; i++) begin
                r_used[i] <= 1'b0;
            end
        end else begin
            r_state <= n_state;
            r_pv    <= sc_issue;
            r_pidx  <= r_idx[ID_W-1:0];
            if (sc_issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (acc) begin
                r_op      <= i_op;
                r_idx     <= '0;
                r_ended   <= '0;
                r_kind    <= rrts_pkg::END_NONE;
                r_started <= 1'b0;
                r_resp    <= '0;
                if (i_op == rrts_pkg::OP_DEFINE && def_ok) begin
                    r_used[def_id] <= 1'b1;
                    r_defined      <= r_defined + CNT_W'(1);
                end
            end
            if (sc_push) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (sc_arrive) begin
                r_arrived <= r_arrived + CNT_W'(1);
            end
            if (sc_wait && r_wait != 32'hFFFF_FFFF) begin
                r_wait <= r_wait + 32'd1;
            end
            if (r_state == rrts_pkg::S_RUN_WR) begin
                r_slice <= boundary ? 9'd0 : slice_nxt;
                if (run_done) begin
                    r_running <= 1'b0;
                    r_ended   <= r_run_idx;
                    r_kind    <= rrts_pkg::END_DONE;
                end else if (r_count != '0 && boundary) begin
                    r_running <= 1'b0;
                    r_ended   <= r_run_idx;
                    r_kind    <= rrts_pkg::END_PREEMPT;
                end
            end
            if (r_state == rrts_pkg::S_DISP_TK) begin
                r_pop_id <= i_ff_rdata;
                r_head   <= (r_head == LastId) ? '0 : r_head + ID_W'(1);
                r_count  <= r_count - CNT_W'(1);
            end
            if (r_state == rrts_pkg::S_DISP_WR) begin
                if (!i_tk_rdata.responded) begin
                    r_resp <= r_tick - i_tk_rdata.arrival;
                end
                r_running <= 1'b1;
                r_run_idx <= r_pop_id;
                r_slice   <= '0;
                r_started <= 1'b1;
            end
            if (r_state == rrts_pkg::S_FINISH && i_out_free &&
                r_op == rrts_pkg::OP_TICK && r_tick != 16'hFFFF) begin
                r_tick <= r_tick + 16'd1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NumC)
        else $error("ready queue count above capacity");

    a_run_defined: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> r_used[r_run_idx])
        else $error("running task slot never defined");

    a_arrived_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_arrived <= r_defined)
        else $error("more tasks arrived than defined");

    a_define_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tk_we && r_state == rrts_pkg::S_IDLE) |-> !r_used[o_tk_waddr])
        else $error("define overwrote a slot in use");

endmodule

/* rtl/core/round_robin_tick_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Round-robin tick scheduler
// Time-slice scheduler over a task table held in RAM, one result per item.
// ----------------------------------------------------------------------------
// Input stream (s_axis): tuser selects define (0) or tick (1); tdata carries
// task_id, arrival_time and burst_time. Every input item gives exactly one
// result item on m_axis.
// Config: i_cfg_we writes i_cfg_wdata into time_slice (reset value 2, 0 acts
// as 256). Write it only while the block is idle.
// Sequence: a define item writes its slot, if free, and goes to the result. A tick
// item visits the task-table RAM one slot per cycle, then the running task is
// read/updated and the queue head is dispatched, each RAM read registered.
// One item is worked on at a time.
// The result sits in an output register; a new item is accepted while that
// result waits. If the receiver stalls, the next finished result waits in
// the sequencer until the register drains.
// Reset (synchronous, active low) marks all slots unused, empties the ready
// queue and clears the time and waiting counters; no clearing pass is needed.
// ----------------------------------------------------------------------------
module round_robin_tick_scheduler_top #(
    parameter int SLOT_CNT = rrts_pkg::NumTasksDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [3:0] task_id, [19:4] arrival_time, [35:20] burst_time
    input  logic [39:0] i_s_axis_tdata,
    // [0] operation
    input  logic [0:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [15:0] current_time, [16] running_valid, [20:17] running task,
    // [24:21] ended_task, [26:25] end_kind, [27] started,
    // [43:28] response_time, [48:44] ready_count, [80:49] total_waiting,
    // [81] all_done
    output logic [87:0] o_m_axis_tdata
);

    localparam int ID_W = $clog2(SLOT_CNT);

    logic [7:0]          r_time_slice;
    logic                r_out_valid;
    rrts_pkg::t_result   r_out;

    logic                tk_we;
    logic [ID_W-1:0]     tk_waddr;
    rrts_pkg::t_task_ent tk_wdata;
    logic [ID_W-1:0]     tk_raddr;
    rrts_pkg::t_task_ent tk_rdata;
    logic                ff_we;
    logic [ID_W-1:0]     ff_waddr;
    logic [ID_W-1:0]     ff_wdata;
    logic [ID_W-1:0]     ff_raddr;
    logic [ID_W-1:0]     ff_rdata;
    logic                out_free;
    logic                res_valid;
    rrts_pkg::t_result   res;

    assign out_free = !r_out_valid || i_m_axis_tready;

    rrts_ram #(
        .WIDTH ($bits(rrts_pkg::t_task_ent)),
        .DEPTH (SLOT_CNT)
    ) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (tk_we),
        .i_waddr (tk_waddr),
        .i_wdata (tk_wdata),
        .i_raddr (tk_raddr),
        .o_rdata (tk_rdata)
    );

    rrts_ram #(
        .WIDTH (ID_W),
        .DEPTH (SLOT_CNT)
    ) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (ff_we),
        .i_waddr (ff_waddr),
        .i_wdata (ff_wdata),
        .i_raddr (ff_raddr),
        .o_rdata (ff_rdata)
    );

    rrts_core #(
        .SLOT_CNT (SLOT_CNT)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_time_slice (r_time_slice),
        .i_in_valid   (i_s_axis_tvalid),
        .i_op         (rrts_pkg::t_op'(i_s_axis_tuser[0])),
        .i_cmd        (rrts_pkg::t_cmd'(i_s_axis_tdata[35:0])),
        .o_in_ready   (o_s_axis_tready),
        .o_tk_we      (tk_we),
        .o_tk_waddr   (tk_waddr),
        .o_tk_wdata   (tk_wdata),
        .o_tk_raddr   (tk_raddr),
        .i_tk_rdata   (tk_rdata),
        .o_ff_we      (ff_we),
        .o_ff_waddr   (ff_waddr),
        .o_ff_wdata   (ff_wdata),
        .o_ff_raddr   (ff_raddr),
        .i_ff_rdata   (ff_rdata),
        .i_out_free   (out_free),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_slice <= 8'(rrts_pkg::TimeSliceRst);
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_time_slice <= i_cfg_wdata;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out};

endmodule

/* tb/tb_round_robin_tick_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Round-robin tick scheduler testbench
// Streams define and tick items into the scheduler, predicts every result
// item with a behavioral copy of the scheduler and compares the whole item.
// ----------------------------------------------------------------------------
module tb_round_robin_tick_scheduler_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NTASK = 16;
    localparam int WDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES = 1500;

    typedef struct packed {
        rrts_pkg::t_op op;
        logic [3:0]    id;
        logic [15:0]   arr;
        logic [15:0]   burst;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [87:0] o_m_axis_tdata;

    round_robin_tick_scheduler_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_s_axis_tvalid(i_s_axis_tvalid), .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata(i_s_axis_tdata), .i_s_axis_tuser(i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid), .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata(o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // scheduler model state
    logic [7:0]       m_slice;
    rrts_pkg::t_phase m_phase [NTASK];
    logic [15:0]      m_arr [NTASK];
    logic [15:0]      m_burst [NTASK];
    logic [15:0]      m_run [NTASK];
    logic             m_resp [NTASK];
    logic [3:0]       m_fifo [NTASK];
    int               m_head, m_cnt, m_ridx, m_scnt, m_defined, m_arrived;
    logic             m_running;
    logic [15:0]      m_tick;
    logic [31:0]      m_wait;

    t_stim             pending [$];
    rrts_pkg::t_result expected_results [$];
    int      n_errors = 0;
    bit      idle_en = 1'b1;
    bit      hold_req = 1'b0;
    bit      hold_done = 1'b0;
    int      hold_cnt = 0;
    bit      in_acc = 1'b0;
    int      wdog = 0;

    task automatic sched_reset();
        m_slice = 8'd2;
        for (int i = 0; i < NTASK; i++) begin
            m_phase[i] = rrts_pkg::PH_UNUSED;
            m_run[i] = '0;
            m_resp[i] = 1'b0;
        end
        m_head = 0; m_cnt = 0; m_ridx = 0; m_scnt = 0;
        m_defined = 0; m_arrived = 0; m_running = 1'b0;
        m_tick = '0; m_wait = '0;
    endtask

    function automatic void queue_task(int id);
        m_fifo[(m_head + m_cnt) % NTASK] = id[3:0];
        m_cnt++;
    endfunction

    function automatic void bump_wait();
        if (m_wait != 32'hFFFF_FFFF) m_wait++;
    endfunction

    function automatic rrts_pkg::t_result predict_schedule(t_stim s);
        rrts_pkg::t_result r;
        logic [15:0]       now;
        int                lim, t;
        bit                bnd;
        r = '0;
        now = m_tick;
        if (s.op == rrts_pkg::OP_DEFINE) begin
            if (m_phase[s.id] == rrts_pkg::PH_UNUSED) begin
                m_phase[s.id] = rrts_pkg::PH_INACTIVE;
                m_arr[s.id] = s.arr;
                m_burst[s.id] = s.burst;
                m_run[s.id] = '0;
                m_resp[s.id] = 1'b0;
                m_defined++;
            end
        end else begin
            for (int i = 0; i < NTASK; i++) begin
                if (m_phase[i] == rrts_pkg::PH_WAITING) begin
                    m_phase[i] = rrts_pkg::PH_READY; queue_task(i); bump_wait();
                end else if (m_phase[i] == rrts_pkg::PH_INACTIVE && m_arr[i] <= now) begin
                    m_phase[i] = rrts_pkg::PH_READY; queue_task(i); m_arrived++;
                end else if (m_phase[i] == rrts_pkg::PH_READY) begin
                    bump_wait();
                end
            end
            if (m_running) begin
                lim = (m_slice == 0) ? 256 : int'(m_slice);
                bnd = 1'b0;
                if (m_run[m_ridx] < 16'hFFFF) m_run[m_ridx]++;
                m_scnt++;
                if (m_scnt >= lim) begin
                    m_scnt = 0; bnd = 1'b1;
                end
                if (m_run[m_ridx] >= m_burst[m_ridx]) begin
                    m_phase[m_ridx] = rrts_pkg::PH_DONE; m_running = 1'b0;
                    r.ended_task = m_ridx[3:0]; r.end_kind = rrts_pkg::END_DONE;
                end else if (m_cnt > 0 && bnd) begin
                    m_phase[m_ridx] = rrts_pkg::PH_WAITING; m_running = 1'b0;
                    r.ended_task = m_ridx[3:0]; r.end_kind = rrts_pkg::END_PREEMPT;
                end
            end
            if (!m_running && m_cnt > 0) begin
                t = int'(m_fifo[m_head]);
                m_head = (m_head + 1) % NTASK;
                m_cnt--;
                if (!m_resp[t]) begin
                    m_resp[t] = 1'b1;
                    r.response_time = now - m_arr[t];
                end
                m_phase[t] = rrts_pkg::PH_RUNNING;
                m_running = 1'b1; m_ridx = t; m_scnt = 0;
                r.started = 1'b1;
            end
            if (m_tick != 16'hFFFF) m_tick++;
        end
        r.current_time = (s.op == rrts_pkg::OP_TICK) ? now : m_tick;
        r.running_valid = m_running;
        r.run_slot = m_running ? m_ridx[3:0] : 4'd0;
        r.ready_count = m_cnt[4:0];
        r.total_waiting = m_wait;
        r.all_done = (m_arrived == m_defined) && m_cnt == 0 && !m_running;
        return r;
    endfunction

    function automatic t_stim mk_define(int id, int arr, int burst);
        t_stim s;
        s.op = rrts_pkg::OP_DEFINE; s.id = id[3:0]; s.arr = arr[15:0];
        s.burst = burst[15:0];
        return s;
    endfunction

    function automatic t_stim mk_tick();
        t_stim s;
        s = '0;
        s.op = rrts_pkg::OP_TICK;
        // payload is ignored on a tick
        s.id = 4'($urandom); s.arr = 16'($urandom); s.burst = 16'($urandom);
        return s;
    endfunction

    // input handshake seen at the last rising edge
    always @(posedge i_clk) begin
        in_acc <= i_s_axis_tvalid && o_s_axis_tready;
    end

    // driver
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && !in_acc) begin
                // hold current item
            end else if (tx_gap > 0) begin
                tx_gap <= tx_gap - 1;
                i_s_axis_tvalid <= 1'b0;
            end else if (pending.size() > 0 &&
                         !(idle_en && $urandom_range(0, 9) == 0)) begin
                t_stim s;
                s = pending.pop_front();
                expected_results.push_back(predict_schedule(s));
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tuser <= s.op;
                i_s_axis_tdata <= {4'd0, s.burst, s.arr, s.id};
            end else begin
                i_s_axis_tvalid <= 1'b0;
                if (idle_en && pending.size() > 0) tx_gap <= $urandom_range(1, 15);
            end
        end
    end

    // receiver ready with random bursts of stall and one long hold
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            i_m_axis_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
            if (hold_cnt >= HOLD_CYCLES - 1) hold_done <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            i_m_axis_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rx_gap <= $urandom_range(1, 15);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        rrts_pkg::t_result got, exp_r;
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) ||
                (o_m_axis_tvalid && i_m_axis_tready))
                wdog <= 0;
            else
                wdog <= wdog + 1;
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = rrts_pkg::t_result'(o_m_axis_tdata[81:0]);
                if (expected_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) $display("unexpected result item %h", got);
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got !== exp_r) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("mismatch: exp t=%0d rv=%b rt=%0d et=%0d ek=%0d st=%b rsp=%0d rc=%0d w=%0d ad=%b | got t=%0d rv=%b rt=%0d et=%0d ek=%0d st=%b rsp=%0d rc=%0d w=%0d ad=%b",
                                exp_r.current_time, exp_r.running_valid, exp_r.run_slot,
                                exp_r.ended_task, exp_r.end_kind, exp_r.started,
                                exp_r.response_time, exp_r.ready_count, exp_r.total_waiting,
                                exp_r.all_done, got.current_time, got.running_valid,
                                got.run_slot, got.ended_task, got.end_kind, got.started,
                                got.response_time, got.ready_count, got.total_waiting,
                                got.all_done);
                    end
                end
            end
            if (wdog >= WDOG_LIMIT) begin
                $display("round_robin_tick_scheduler_top regression: fail");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending.size() > 0 || i_s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic write_slice(logic [7:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        m_slice = v;
    endtask

    // random task set plus ticks; tasks mostly arrive soon after the current tick
    task automatic add_phase(int n_items);
        int base;
        base = int'(m_tick);
        for (int i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 5) == 0) begin
                int a;
                a = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 40);
                if ($urandom_range(0, 19) == 0) a = 16'hFFFF;
                pending.push_back(mk_define($urandom_range(0, 15), a,
                    ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 12)));
            end else begin
                pending.push_back(mk_tick());
            end
        end
    endtask

    initial begin
        sched_reset();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero burst, max burst, late arrival, redefine, slot extremes
        pending.push_back(mk_tick());
        pending.push_back(mk_define(0, 0, 0));
        pending.push_back(mk_define(15, 16'hFFFF, 16'hFFFF));
        pending.push_back(mk_define(0, 5, 5));
        pending.push_back(mk_define(3, 0, 1));
        pending.push_back(mk_define(7, 2, 4));
        pending.push_back(mk_define(8, 0, 6));
        for (int i = 0; i < 14; i++) pending.push_back(mk_tick());
        wait_drained();

        // slice change below ticks already run in the current slice
        write_slice(8'd255);
        pending.push_back(mk_define(9, 0, 9));
        pending.push_back(mk_define(10, 0, 9));
        for (int i = 0; i < 5; i++) pending.push_back(mk_tick());
        wait_drained();
        write_slice(8'd1);
        add_phase(150);

        // long receiver stall while sender keeps offering
        hold_req = 1'b1;
        wait (hold_done);
        wait_drained();

        // zero slice acts as 256
        write_slice(8'd0);
        add_phase(200);
        wait_drained();
        write_slice(8'd3);
        add_phase(250);
        wait_drained();
        write_slice(8'($urandom_range(1, 255)));
        add_phase(250);
        wait_drained();

        // last stretch without idling
        idle_en = 1'b0;
        write_slice(8'd2);
        add_phase(150);
        wait_drained();

        if (n_errors == 0)
            $display("round_robin_tick_scheduler_top regression: pass");
        else
            $display("round_robin_tick_scheduler_top regression: fail");
        $finish;
    end
endmodule

/* filelist.f */
rtl/core/rrts_pkg.sv
rtl/core/rrts_ram.sv
rtl/core/rrts_core.sv
rtl/core/round_robin_tick_scheduler_top.sv
tb/tb_round_robin_tick_scheduler_top.sv
